// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication, switched off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// File: sv/yuvrgb_pkg.sv
// shared constants and types of the yuv to rgb pixel converter
`default_nettype none

package yuvrgb_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_W           = 16;   // width of the full-scale register
   localparam int LEVEL_W         = 8;    // rescaled sample and colour width
   localparam int REM_W           = LEVEL_W + MAX_W;
   localparam int LANES           = 3;
   localparam int CSR_IDX_W       = 2;
   localparam int PROD_W          = 20;
   localparam int SUM_W           = 22;

   localparam logic [MAX_W-1:0] MAX_VALUE_DEF = 16'd1023;

   localparam logic [LEVEL_W-1:0] NEUTRAL_CHROMA = 8'd128;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 8'd255;

   localparam logic signed [PROD_W-1:0] LUMA_OFFSET   = 20'sd16;
   localparam logic signed [PROD_W-1:0] CHROMA_OFFSET = 20'sd128;
   localparam logic signed [PROD_W-1:0] COEF_Y        = 20'sd298;
   localparam logic signed [PROD_W-1:0] COEF_R_CR     = 20'sd409;
   localparam logic signed [PROD_W-1:0] COEF_G_CB     = 20'sd100;
   localparam logic signed [PROD_W-1:0] COEF_G_CR     = 20'sd208;
   localparam logic signed [PROD_W-1:0] COEF_B_CB     = 20'sd516;
   localparam logic signed [SUM_W-1:0]  ROUND_TERM    = 22'sd128;

   localparam logic [CSR_IDX_W-1:0] REG_DEEP_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VALUE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHROMA_PRESENT = 2'd2;

   // 8-bit mode samples that ride alongside the rescale pipeline
   typedef struct packed {
      logic [LEVEL_W-1:0] luma;
      logic [LEVEL_W-1:0] cb;
      logic [LEVEL_W-1:0] cr;
   } plain_type;

endpackage

`default_nettype wire

// File: sv/planar_yuv_to_rgb_pixel_top.sv
// BT.601 limited-range yuv to rgb pixel converter, top level
//
// input channel req_*: one pixel word per handshake (luma, Cb, Cr samples);
// only the low SAMPLE_BITS bits of each sample count.
// result channel rsp_*: one word of clamped 8-bit red, green and blue per pixel.
// csr_*: write-only registers, index 0 deep_mode, 1 max_value, 2 chroma_present;
// other indexes are dropped. write them only while no pixel is in flight.
// throughput: one pixel per clock unless the output word is held; the rescale divide
// resolves one quotient bit per stage over eight stages, followed by a multiply stage
// and a sum and clamp stage.
// reset (synchronous) empties the pipeline and loads the register defaults
// deep_mode 0, max_value 1023, chroma_present 1.
// when the receiver holds rsp_ready low with a word waiting, the whole pipeline
// freezes and req_ready drops; nothing is lost or repeated.
`default_nettype none

module planar_yuv_to_rgb_pixel_top
   import yuvrgb_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [15:0]          req_luma,
   input  wire logic [15:0]          req_chroma_blue,
   input  wire logic [15:0]          req_chroma_red,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [LEVEL_W-1:0]        rsp_red,
   output logic [LEVEL_W-1:0]        rsp_green,
   output logic [LEVEL_W-1:0]        rsp_blue,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [MAX_W-1:0]     csr_wdata
);

   localparam int NUM_W = SAMPLE_BITS + 9;

   logic             deep_mode_ff;
   logic [MAX_W-1:0] max_value_ff;
   logic             chroma_present_ff;
   logic [MAX_W-1:0] full_scale;

   logic                   advance;
   logic [SAMPLE_BITS-1:0] samp [LANES];
   logic [SAMPLE_BITS-1:0] deep_samp [LANES];
   logic [NUM_W-1:0]       num [LANES];
   plain_type              plain_in;

   logic               div_valid;
   logic [LEVEL_W-1:0] div_level [LANES];
   plain_type          div_side;
   logic [LEVEL_W-1:0] level [LANES];

   logic signed [PROD_W-1:0] c_val, d_val, e_val;
   logic                     prod_valid_ff;
   logic signed [PROD_W-1:0] y_term_ff, r_cr_ff, g_cb_ff, g_cr_ff, b_cb_ff;

   logic signed [SUM_W-1:0] red_sum, green_sum, blue_sum;
   logic                    rsp_valid_ff;
   logic [LEVEL_W-1:0]      red_ff, green_ff, blue_ff;

   function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [SUM_W-1:0] sum);
      logic [SUM_W-9:0] shifted;
      begin
         shifted = sum[SUM_W-1:8];
         if (sum[SUM_W-1]) begin
            clamp_level = '0;
         end else if (shifted > (SUM_W-8)'(LEVEL_MAX)) begin
            clamp_level = LEVEL_MAX;
         end else begin
            clamp_level = shifted[LEVEL_W-1:0];
         end
      end
   endfunction

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deep_mode_ff      <= 1'b0;
         max_value_ff      <= MAX_VALUE_DEF;
         chroma_present_ff <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_DEEP_MODE:      deep_mode_ff      <= csr_wdata[0];
            REG_MAX_VALUE:      max_value_ff      <= csr_wdata;
            REG_CHROMA_PRESENT: chroma_present_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign full_scale = (max_value_ff == '0) ? MAX_VALUE_DEF : max_value_ff;

   // whole pipeline moves unless the output word is held
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // entry: sample select and rescale numerator s*255 + m/2
   assign samp[0] = req_luma[SAMPLE_BITS-1:0];
   assign samp[1] = req_chroma_blue[SAMPLE_BITS-1:0];
   assign samp[2] = req_chroma_red[SAMPLE_BITS-1:0];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (i != 0 && !chroma_present_ff) begin
            deep_samp[i] = SAMPLE_BITS'(full_scale >> 1);
         end else begin
            deep_samp[i] = samp[i];
         end
         num[i] = (NUM_W'({deep_samp[i], {LEVEL_W{1'b0}}}) - NUM_W'(deep_samp[i]))
                  + NUM_W'(full_scale >> 1);
      end
   end

   assign plain_in.luma = samp[0][LEVEL_W-1:0];
   assign plain_in.cb   = chroma_present_ff ? samp[1][LEVEL_W-1:0] : NEUTRAL_CHROMA;
   assign plain_in.cr   = chroma_present_ff ? samp[2][LEVEL_W-1:0] : NEUTRAL_CHROMA;

   yuvrgb_rescale #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_rescale (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_valid),
      .in_num    (num),
      .in_side   (plain_in),
      .divisor   (full_scale),
      .out_valid (div_valid),
      .out_level (div_level),
      .out_side  (div_side)
   );

   assign level[0] = deep_mode_ff ? div_level[0] : div_side.luma;
   assign level[1] = deep_mode_ff ? div_level[1] : div_side.cb;
   assign level[2] = deep_mode_ff ? div_level[2] : div_side.cr;

   assign c_val = $signed(PROD_W'(level[0])) - LUMA_OFFSET;
   assign d_val = $signed(PROD_W'(level[1])) - CHROMA_OFFSET;
   assign e_val = $signed(PROD_W'(level[2])) - CHROMA_OFFSET;

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         y_term_ff <= c_val * COEF_Y;
         r_cr_ff   <= e_val * COEF_R_CR;
         g_cb_ff   <= d_val * COEF_G_CB;
         g_cr_ff   <= e_val * COEF_G_CR;
         b_cb_ff   <= d_val * COEF_B_CB;
      end
   end

   // sum, round and clamp into the output register
   assign red_sum   = SUM_W'(y_term_ff) + SUM_W'(r_cr_ff) + ROUND_TERM;
   assign green_sum = SUM_W'(y_term_ff) - SUM_W'(g_cb_ff) - SUM_W'(g_cr_ff) + ROUND_TERM;
   assign blue_sum  = SUM_W'(y_term_ff) + SUM_W'(b_cb_ff) + ROUND_TERM;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= clamp_level(red_sum);
         green_ff <= clamp_level(green_sum);
         blue_ff  <= clamp_level(blue_sum);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

`default_nettype wire

// File: sv/yuvrgb_rescale.sv
// pipelined rescale of three samples: saturation check then one quotient bit per stage
`default_nettype none

module yuvrgb_rescale
   import yuvrgb_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           enable,
   input  wire logic                           in_valid,
   input  wire logic [SAMPLE_BITS+8:0]         in_num [LANES],
   input  wire plain_type                      in_side,
   input  wire logic [MAX_W-1:0]               divisor,
   output logic                                out_valid,
   output logic [LEVEL_W-1:0]                  out_level [LANES],
   output plain_type                           out_side
);

   localparam int NUM_W = SAMPLE_BITS + 9;
   localparam int CMP_W = (NUM_W > REM_W) ? NUM_W : REM_W;
   localparam int STEPS = LEVEL_W;

   logic               valid_ff [0:STEPS];
   plain_type          side_ff  [0:STEPS];
   logic [REM_W-1:0]   rem_ff   [0:STEPS-1][0:LANES-1];
   logic [LEVEL_W-1:0] quo_ff   [0:STEPS][0:LANES-1];
   logic               sat_ff   [0:STEPS][0:LANES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= in_side;
      end
   end

   genvar l, k;
   generate
      for (l = 0; l < LANES; l++) begin : g_entry
         // quotient at or above 256 saturates, otherwise it fits the remainder width
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[0][l] <= REM_W'(in_num[l]);
               quo_ff[0][l] <= '0;
               sat_ff[0][l] <= CMP_W'(in_num[l]) >= CMP_W'({divisor, {LEVEL_W{1'b0}}});
            end
         end
      end

      for (k = 1; k <= STEPS; k++) begin : g_step
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (enable) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               side_ff[k] <= side_ff[k-1];
            end
         end

         for (l = 0; l < LANES; l++) begin : g_lane
            logic [REM_W-1:0] shifted;
            logic [REM_W:0]   diff;

            assign shifted = REM_W'(divisor) << (STEPS - k);
            assign diff    = {1'b0, rem_ff[k-1][l]} - {1'b0, shifted};

            always_ff @(posedge clock) begin
               if (enable) begin
                  quo_ff[k][l] <= quo_ff[k-1][l]
                                  | (LEVEL_W'(!diff[REM_W]) << (STEPS - k));
                  sat_ff[k][l] <= sat_ff[k-1][l];
               end
            end

            if (k < STEPS) begin : g_rem
               always_ff @(posedge clock) begin
                  if (enable) begin
                     rem_ff[k][l] <= diff[REM_W] ? rem_ff[k-1][l] : diff[REM_W-1:0];
                  end
               end
            end
         end
      end

      for (l = 0; l < LANES; l++) begin : g_out
         assign out_level[l] = sat_ff[STEPS][l] ? LEVEL_MAX : quo_ff[STEPS][l];
      end
   endgenerate

   assign out_valid = valid_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule

`default_nettype wire

// File: sv/yuvrgb_checker.sv
// port-level checks on the converter and their binding to the top level
`default_nettype none

`include "assert_macros.svh"

module yuvrgb_checker
   import yuvrgb_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [LEVEL_W-1:0]   rsp_red,
   input wire logic [LEVEL_W-1:0]   rsp_green,
   input wire logic [LEVEL_W-1:0]   rsp_blue
);

   // a held output word must also hold off new input words
   `ASSERT_IMPLY(a_stall_blocks_input, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // with no word on the output the pipeline is free to take input
   `ASSERT_IMPLY(a_empty_output_ready, clock, reset, !rsp_valid, req_ready)

   // reset leaves no word on the output
   `ASSERT_NEXT_ALWAYS(a_reset_clears_output, clock, reset, !rsp_valid)

   // a stalled word keeps its colours
   `ASSERT_NEXT(a_stalled_word_holds, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))

endmodule

bind planar_yuv_to_rgb_pixel_top yuvrgb_checker u_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
// self-checking testbench for the yuv to rgb pixel converter
`default_nettype none

module tb_top;
   import yuvrgb_pkg::*;

   localparam int SAMPLE_W    = SAMPLE_BITS_DEF;
   localparam int K_Y         = 298;
   localparam int K_R_CR      = 409;
   localparam int K_G_CB      = 100;
   localparam int K_G_CR      = 208;
   localparam int K_B_CB      = 516;
   localparam int Y_BLACK     = 16;
   localparam int C_ZERO      = 128;
   localparam int ROUNDING    = 128;
   localparam int M_FALLBACK  = 1023;
   localparam int PIPE_CYCLES = 12;
   localparam int RAND_PHASES = 9;
   localparam int PHASE_ITEMS = 50;
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 2'd3;

   typedef struct packed {
      logic [15:0] luma;
      logic [15:0] cb;
      logic [15:0] cr;
   } pixel_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } rgb_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [15:0]          req_luma = '0;
   logic [15:0]          req_chroma_blue = '0;
   logic [15:0]          req_chroma_red = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]   rsp_red;
   logic [LEVEL_W-1:0]   rsp_green;
   logic [LEVEL_W-1:0]   rsp_blue;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MAX_W-1:0]     csr_wdata = '0;

   // register copies as the block should hold them
   logic                 deep_cfg = 1'b0;
   logic [MAX_W-1:0]     max_cfg = MAX_VALUE_DEF;
   logic                 chroma_cfg = 1'b1;

   pixel_word_type pixel_q[$];
   rgb_word_type   expected_rgb_q[$];
   int             send_idle_pct = 12;
   int             recv_idle_pct = 66;
   int             errors = 0;

   planar_yuv_to_rgb_pixel_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_luma        (req_luma),
      .req_chroma_blue (req_chroma_blue),
      .req_chroma_red  (req_chroma_red),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int scale_to_level(int unsigned s, int unsigned m);
      int unsigned q;
      q = (s * 255 + m / 2) / m;
      return (q > 255) ? 255 : int'(q);
   endfunction

   function automatic logic [LEVEL_W-1:0] clamp_level(int sum);
      int v;
      if (sum < 0) return '0;
      v = sum >>> 8;
      return (v > 255) ? LEVEL_MAX : v[LEVEL_W-1:0];
   endfunction

   function automatic rgb_word_type predict_rgb(pixel_word_type px);
      int unsigned  ys, us, vs, m;
      int           yv, uv, vv, c, d, e;
      rgb_word_type res;
      ys = px.luma & ((1 << SAMPLE_W) - 1);
      us = px.cb & ((1 << SAMPLE_W) - 1);
      vs = px.cr & ((1 << SAMPLE_W) - 1);
      if (deep_cfg) begin
         m = (max_cfg == 0) ? M_FALLBACK : max_cfg;
         if (!chroma_cfg) begin
            us = m / 2;
            vs = m / 2;
         end
         yv = scale_to_level(ys, m);
         uv = scale_to_level(us, m);
         vv = scale_to_level(vs, m);
      end else begin
         yv = ys & 255;
         uv = chroma_cfg ? int'(us & 255) : int'(NEUTRAL_CHROMA);
         vv = chroma_cfg ? int'(vs & 255) : int'(NEUTRAL_CHROMA);
      end
      c = yv - Y_BLACK;
      d = uv - C_ZERO;
      e = vv - C_ZERO;
      res.red   = clamp_level(K_Y * c + K_R_CR * e + ROUNDING);
      res.green = clamp_level(K_Y * c - K_G_CB * d - K_G_CR * e + ROUNDING);
      res.blue  = clamp_level(K_Y * c + K_B_CB * d + ROUNDING);
      return res;
   endfunction

   // driver: a new word goes out only once the held one has been taken
   always @(posedge clock) begin : pixel_driver
      pixel_word_type nxt;
      pixel_word_type taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            taken = '{req_luma, req_chroma_blue, req_chroma_red};
            expected_rgb_q.push_back(predict_rgb(taken));
         end
         if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pixel_q.pop_front();
            req_valid       <= 1'b1;
            req_luma        <= nxt.luma;
            req_chroma_blue <= nxt.cb;
            req_chroma_red  <= nxt.cr;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rgb_monitor
      rgb_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rgb_q.size() == 0) begin
               $display("%0t: rgb word with none expected, actual %0d %0d %0d",
                        $time, rsp_red, rsp_green, rsp_blue);
               errors++;
            end else begin
               want = expected_rgb_q.pop_front();
               if (rsp_red !== want.red) begin
                  $display("%0t: red expected %0d actual %0d", $time, want.red, rsp_red);
                  errors++;
               end
               if (rsp_green !== want.green) begin
                  $display("%0t: green expected %0d actual %0d",
                           $time, want.green, rsp_green);
                  errors++;
               end
               if (rsp_blue !== want.blue) begin
                  $display("%0t: blue expected %0d actual %0d", $time, want.blue, rsp_blue);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_pixel(input logic [15:0] y, input logic [15:0] cb,
                              input logic [15:0] cr);
      pixel_q.push_back('{y, cb, cr});
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pixel_q.size() != 0 || req_valid || expected_rgb_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [MAX_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_DEEP_MODE:      deep_cfg = data[0];
         REG_MAX_VALUE:      max_cfg = data;
         REG_CHROMA_PRESENT: chroma_cfg = data[0];
         default: ;
      endcase
   endtask

   // only once the pipeline is empty; upper bits of the flag writes are junk
   task automatic set_config(input logic deep, input logic [MAX_W-1:0] maxv,
                             input logic chroma);
      wait_drained();
      repeat (PIPE_CYCLES) @(negedge clock);
      write_reg(REG_DEEP_MODE, {16'($urandom) & 16'hFFFE} | deep);
      write_reg(REG_MAX_VALUE, maxv);
      write_reg(REG_CHROMA_PRESENT, {16'($urandom) & 16'hFFFE} | chroma);
   endtask

   // mostly in range, with the extremes and full 16-bit noise mixed in
   function automatic logic [15:0] gen_sample(int unsigned full);
      case ($urandom_range(9))
         0:       return 16'($urandom);
         1:       return '0;
         2:       return full[15:0];
         default: return 16'($urandom_range(full));
      endcase
   endfunction

   initial begin : stimulus
      int unsigned m;
      logic [MAX_W-1:0] maxv;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // 8-bit mode straight after reset: extremes, clamping, wide samples
      queue_pixel(16'd0, 16'd0, 16'd0);
      queue_pixel(16'd255, 16'd255, 16'd255);
      queue_pixel(16'd16, 16'd128, 16'd128);
      queue_pixel(16'd235, 16'd240, 16'd240);
      queue_pixel(16'd255, 16'd0, 16'd255);
      queue_pixel(16'd0, 16'd255, 16'd0);
      queue_pixel(16'h1234, 16'hFF80, 16'hAB10);
      queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_pixel(16'hFF00, 16'h00FF, 16'h5A5A);

      // deep mode at the default full scale, including samples above it
      set_config(1'b1, 16'd1023, 1'b1);
      queue_pixel(16'd0, 16'd0, 16'd0);
      queue_pixel(16'd1023, 16'd1023, 16'd1023);
      queue_pixel(16'd1024, 16'd2000, 16'hFFFF);
      queue_pixel(16'd64, 16'd512, 16'd512);
      queue_pixel(16'd940, 16'd960, 16'd64);
      queue_pixel(16'hFFFF, 16'd0, 16'd1023);

      // zero full scale stands for 1023; neutral chroma replaces inputs
      set_config(1'b1, 16'd0, 1'b0);
      queue_pixel(16'd1023, 16'hFFFF, 16'd0);
      queue_pixel(16'd0, 16'd0, 16'hFFFF);
      wait_drained();
      write_reg(REG_NONE, 16'hFFFF);
      queue_pixel(16'd512, 16'h5555, 16'hAAAA);
      set_config(1'b1, 16'hFFFF, 1'b1);
      queue_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
      queue_pixel(16'h8000, 16'h0000, 16'hFFFF);

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 12;
            recv_idle_pct = 66;
         end else if (phase < 6) begin
            send_idle_pct = 66;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0: set_config(1'b0, 16'($urandom), 1'b1);
            1: set_config(1'b1, 16'd1023, 1'b1);
            2: set_config(1'b1, 16'd0, 1'b0);
            3: set_config(1'b1, 16'hFFFF, 1'b1);
            4: set_config(1'b1, 16'd1, 1'b1);
            5: set_config(1'b0, 16'($urandom), 1'b0);
            6: set_config(1'b1, 16'($urandom_range(65535, 1)), 1'($urandom_range(1)));
            7: set_config(1'b1, 16'd255, 1'b0);
            default: set_config(1'b1, 16'($urandom_range(4095, 2)), 1'b1);
         endcase
         if (phase == 3)
            write_reg(REG_NONE, 16'($urandom));
         maxv = max_cfg;
         m = !deep_cfg ? 255 : (maxv == 0) ? M_FALLBACK : maxv;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold the sender back until the pipeline has emptied
            if (phase == 4 && i == PHASE_ITEMS / 2)
               wait_drained();
            queue_pixel(gen_sample(m), gen_sample(m), gen_sample(m));
         end
      end

      wait_drained();
      repeat (PIPE_CYCLES * 2) @(negedge clock);
      if (expected_rgb_q.size() != 0)
         errors++;
      if (errors == 0) begin
         $display("planar_yuv_to_rgb_pixel_top: match");
      end else begin
         $display("planar_yuv_to_rgb_pixel_top: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("planar_yuv_to_rgb_pixel_top: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/yuvrgb_pkg.sv
sv/yuvrgb_rescale.sv
sv/planar_yuv_to_rgb_pixel_top.sv
sv/yuvrgb_checker.sv
test/tb_top.sv
